// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by pfc_checker in this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked check that also holds across reset
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hdl/pfc_pkg.sv =====
// ---------------------------------------------------------------------------
// pfc_pkg
// Widths, sequencer states and divider interface types for the prime
// factor counter.
// ---------------------------------------------------------------------------
package pfc_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int REM_BITS       = VALUE_BITS - 1;
  localparam int DIV_BITS       = (VALUE_BITS + 1) / 2;
  localparam int STEP_BITS      = $clog2(REM_BITS);
  localparam int COUNT_BITS     = 5;
  localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((COUNT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = COUNT_BITS'(31);
  localparam logic [DIV_BITS-1:0]   FIRST_DIVISOR = DIV_BITS'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                start;
    logic [REM_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [REM_BITS-1:0] quot;
    logic [DIV_BITS-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hdl/prime_factor_count.sv =====
// ---------------------------------------------------------------------------
// prime_factor_count: big omega of a signed integer by trial division
// Values at or below one skip the divider and go straight to the finish
// state. Otherwise each trial division runs in the bit-serial divider.
// One item at a time.
// Synchronous active-low reset clears the sequencer and output valid.
// ---------------------------------------------------------------------------
module prime_factor_count (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pfc_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfc_pkg::OUT_TDATA_BITS-1:0]  out_tdata   // factor_count
);
  import pfc_pkg::*;

  state_t                state_r, state_nxt;
  logic [REM_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   dsr_r, dsr_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [COUNT_BITS-1:0] out_data_r;

  logic                  in_accept;
  logic [VALUE_BITS-1:0] raw;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  load_out;
  logic                  start;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  pfc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign raw       = in_tdata[VALUE_BITS-1:0];
  assign cnt_inc   = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_BITS'(1);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    cnt_nxt   = cnt_r;
    start     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cnt_nxt = '0;
          dsr_nxt = FIRST_DIVISOR;
          if (!raw[VALUE_BITS-1] && raw[REM_BITS-1:0] > REM_BITS'(1)) begin
            rem_nxt   = raw[REM_BITS-1:0];
            start     = 1'b1;
            state_nxt = S_DIV;
          end else begin
            rem_nxt   = '0;
            state_nxt = S_FINISH;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (REM_BITS'(dsr_r) > div_rsp.quot) begin
            if (rem_r > REM_BITS'(1)) begin
              cnt_nxt = cnt_inc;
            end
            state_nxt = S_FINISH;
          end else if (div_rsp.rem == '0) begin
            rem_nxt = div_rsp.quot;
            cnt_nxt = cnt_inc;
            start   = 1'b1;
          end else begin
            dsr_nxt = dsr_r + DIV_BITS'(1);
            start   = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end

    div_req.start    = start;
    div_req.dividend = rem_nxt;
    div_req.divisor  = dsr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      dsr_r      <= FIRST_DIVISOR;
      cnt_r      <= '0;
      out_data_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      dsr_r <= dsr_nxt;
      cnt_r <= cnt_nxt;
      if (load_out) begin
        out_data_r <= cnt_r;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_BITS - COUNT_BITS)'(0), out_data_r};

endmodule

// ===== hdl/pfc_div.sv =====
// ---------------------------------------------------------------------------
// pfc_div
// Restoring divider, one quotient bit per cycle. Loads on start, raises
// done for one cycle with quotient and remainder after REM_BITS steps.
// ---------------------------------------------------------------------------
module pfc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pfc_pkg::div_req_t req,
  output pfc_pkg::div_rsp_t rsp
);
  import pfc_pkg::*;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(REM_BITS - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_BITS-1:0] cnt_r;
  logic [REM_BITS-1:0]  quot_r;
  logic [DIV_BITS-1:0]  part_r;
  logic [DIV_BITS-1:0]  dsr_r;

  logic [DIV_BITS:0]    shifted;
  logic [DIV_BITS:0]    diff;
  logic                 borrow;
  logic [DIV_BITS-1:0]  part_nxt;

  always_comb begin
    shifted  = {part_r, quot_r[REM_BITS-1]};
    diff     = shifted - {1'b0, dsr_r};
    borrow   = diff[DIV_BITS];
    part_nxt = borrow ? shifted[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_BITS'(1);
        if (cnt_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      part_r <= '0;
      dsr_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[REM_BITS-2:0], ~borrow};
      part_r <= part_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = part_r;

endmodule

// ===== hdl/pfc_checker.sv =====
// ---------------------------------------------------------------------------
// pfc_checker
// Port-level checks on the prime factor counter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [pfc_pkg::OUT_TDATA_BITS-1:0] out_tdata
);
  import pfc_pkg::*;

  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `ASSERT_CLK_RST(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[OUT_TDATA_BITS-1:COUNT_BITS] == '0)
  `ASSERT_CLK_RST(a_busy_after_in, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `ASSERT_CLK(a_reset_clear, clk, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind prime_factor_count pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_prime_factor_count.sv =====
// ---------------------------------------------------------------------------
// tb_prime_factor_count
// Self-checking bench for the big omega counter. A driver feeds signed
// values from a queue in bursts with random gaps. A monitor predicts the
// prime factor count of every accepted value and compares each result
// transfer in order, while the receiver stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module tb_prime_factor_count;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    bit                    drain;
  } factor_job_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;

  factor_job_t               job_q[$];
  logic [COUNT_BITS-1:0]     count_q[$];
  int                        outstanding = 0;
  int                        error_count = 0;
  int                        burst_left  = 0;
  int                        gap_left    = 0;
  int                        rx_mode     = 0;
  int                        rx_phase    = 0;
  longint                    cycle_count = 0;

  prime_factor_count i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [COUNT_BITS-1:0] big_omega(logic [VALUE_BITS-1:0] v);
    longint unsigned rest;
    longint unsigned divisor;
    int unsigned     n;
    n = 0;
    if (v[VALUE_BITS-1]) return '0;
    rest = 64'(v);
    divisor = 2;
    if (rest > 1) begin
      while (divisor <= rest / divisor) begin
        if (rest % divisor == 0) begin
          rest = rest / divisor;
          if (n < COUNT_MAX) n++;
        end else begin
          divisor++;
        end
      end
      if (rest > 1 && n < COUNT_MAX) n++;
    end
    return COUNT_BITS'(n);
  endfunction

  function automatic logic [VALUE_BITS-1:0] smooth_value();
    int unsigned     primes[6] = '{2, 3, 5, 7, 11, 13};
    longint unsigned prod;
    int unsigned     p;
    int              k;
    prod = 1;
    k = $urandom_range(1, 30);
    repeat (k) begin
      p = primes[$urandom_range(0, 5)];
      if (prod * p <= 64'h7FFF_FFFF) prod = prod * p;
    end
    return VALUE_BITS'(prod);
  endfunction

  task automatic add_job(logic [VALUE_BITS-1:0] v, bit drain);
    factor_job_t j;
    j.value = v;
    j.drain = drain;
    job_q.insert(job_q.size(), j);
  endtask

  // driver
  always @(posedge clk) begin
    int          pending;
    factor_job_t j;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      pending = outstanding + (in_tvalid && in_tready) - (out_tvalid && out_tready);
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (job_q.size() == 0 || (job_q[0].drain && pending != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        j = job_q[0];
        job_q.delete(0);
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_BITS'(j.value);
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rx_phase == 0) rx_mode <= $urandom_range(0, 2);
    rx_phase <= (rx_phase + 1) % 64;
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // monitor
  always @(posedge clk) begin
    logic [COUNT_BITS-1:0] want;
    if (!rst_n) begin
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (count_q.size() == 0) begin
          $error("unexpected transfer: factor_count actual %0d",
                 out_tdata[COUNT_BITS-1:0]);
          error_count++;
        end else begin
          want = count_q[0];
          count_q.delete(0);
          if (out_tdata[COUNT_BITS-1:0] !== want) begin
            $error("factor_count mismatch: expected %0d actual %0d",
                   want, out_tdata[COUNT_BITS-1:0]);
            error_count++;
          end
        end
        if (out_tdata[OUT_TDATA_BITS-1:COUNT_BITS] !== '0) begin
          $error("tdata padding mismatch: expected 0 actual %0h",
                 out_tdata[OUT_TDATA_BITS-1:COUNT_BITS]);
          error_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        count_q.insert(count_q.size(), big_omega(in_tdata[VALUE_BITS-1:0]));
      end
      outstanding <= outstanding + (in_tvalid && in_tready) - (out_tvalid && out_tready);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    add_job(32'd0, 1'b0);
    add_job(32'd1, 1'b0);
    add_job(32'hFFFF_FFFF, 1'b0);
    add_job(32'h8000_0000, 1'b0);
    add_job(32'd2, 1'b0);
    add_job(32'd3, 1'b1);
    add_job(32'd4, 1'b0);
    add_job(32'd6, 1'b0);
    add_job(32'd9, 1'b0);
    add_job(32'd25, 1'b0);
    add_job(32'd49, 1'b0);
    add_job(32'd97, 1'b0);
    add_job(32'd360, 1'b0);
    add_job(32'd1024, 1'b0);
    add_job(32'd1_000_003, 1'b0);
    add_job(32'h4000_0000, 1'b0);
    add_job(32'd1_162_261_467, 1'b0);
    add_job(32'h7FFF_FFFE, 1'b0);
    add_job(32'h7FFF_FFFF, 1'b1);
    add_job(32'h8000_0001, 1'b0);
    add_job(32'h5555_5555 | 32'h8000_0000, 1'b0);
    repeat (80) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_job($urandom | 32'h8000_0000, 1'b0);
      end else if (r < 20) begin
        add_job($urandom_range(0, 1), 1'b0);
      end else if (r < 65) begin
        add_job($urandom_range(2, 4096), ($urandom_range(0, 19) == 0));
      end else if (r < 92) begin
        add_job(smooth_value(), 1'b0);
      end else begin
        add_job($urandom_range(4097, 1 << 20), 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (job_q.size() != 0 || in_tvalid || outstanding != 0 || count_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && count_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
